// ----- design/tse_pkg.sv -----
package tse_pkg;

  // Graph limits
  localparam int MAX_NODES = 64;
  localparam int MAX_EDGES = 256;

  // Fixed field widths
  localparam int NODE_W  = 6;
  localparam int COUNT_W = 7;
  localparam int CMD_W   = 2;

  // Derived widths
  localparam int NODE_AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int NODE_CW = $clog2(MAX_NODES + 1);
  localparam int EDGE_AW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int EDGE_CW = $clog2(MAX_EDGES + 1);
  localparam int DEG_W   = $clog2(MAX_EDGES + 1);

  // Command codes
  localparam logic [CMD_W-1:0] CMD_ADD_EDGE    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CLEAR_EDGES = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SORT_NODES  = 2'd2;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_SCAN_ISSUE,
    ST_SCAN_CHECK,
    ST_SCAN_UPDATE,
    ST_INIT_ISSUE,
    ST_INIT_CHECK,
    ST_POP_ISSUE,
    ST_POP_DATA,
    ST_EMIT_ISSUE,
    ST_EMIT_DATA
  } tse_state_t;

endpackage

// ----- design/tse_ram.sv -----
module tse_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- design/topological_sort_engine_unit.sv -----
// Kahn topological sort engine.
// Command channel (cmd_valid/cmd_ready): command, source_node, dest_node.
//   add_edge stores an edge; clear_edges empties the store; sort_nodes runs a
//   full sort and then streams its results.
// Result channel (res_valid/res_ready): node_index, has_node, last_of_run,
//   cycle_found. An empty order gives one transaction with has_node low.
// The user must write node_count through cfg_wr_en/cfg_wr_data only while the
// block is idle; the block itself does not enforce this. A sort first clears
// all MAX_NODES entries of the in-degree memory, then scans the stored edges
// to count in-degrees, checks each node to seed the queue, and for each dequeued
// node scans the stored edges again to lower the in-degree of its destinations.
// The scan through the edge memory's single read port dominates a full sort.
// Each result then leaves the queue memory through an issue and a data state.
// cmd_ready is high only while idle; the next command is taken while the
// last result still waits in the output register. A stalled receiver holds
// the output register and the emit sequence waits for it.
// Reset clears the edge count, node_count and the output valid; the memories
// need no clearing.
module topological_sort_engine_unit
  import tse_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [COUNT_W-1:0] cfg_wr_data,
  input  logic               cmd_valid,
  output logic               cmd_ready,
  input  logic [CMD_W-1:0]   command,
  input  logic [NODE_W-1:0]  source_node,
  input  logic [NODE_W-1:0]  dest_node,
  output logic               res_valid,
  input  logic               res_ready,
  output logic [NODE_W-1:0]  node_index,
  output logic               has_node,
  output logic               last_of_run,
  output logic               cycle_found
);

  tse_state_t state, state_next;

  logic [COUNT_W-1:0] node_count;
  logic [COUNT_W-1:0] live_n;
  logic [EDGE_CW-1:0] edge_total;
  logic [EDGE_CW-1:0] ep;
  logic [EDGE_CW-1:0] ep_inc;
  logic               scan_more;
  logic [NODE_CW-1:0] ni;
  logic [NODE_CW-1:0] ni_inc;
  logic [NODE_CW-1:0] head;
  logic [NODE_CW-1:0] tail;
  logic [NODE_W-1:0]  node;
  logic [NODE_W-1:0]  cur_dst;
  logic               releasing;
  logic               cyc;

  // Memory ports
  logic                        edge_we;
  logic [EDGE_AW-1:0]          edge_raddr;
  logic [2*NODE_W-1:0]         edge_rdata;
  logic [NODE_W-1:0]           e_src, e_dst;
  logic                        deg_we;
  logic [NODE_AW-1:0]          deg_waddr, deg_raddr;
  logic [DEG_W-1:0]            deg_wdata, deg_rdata;
  logic                        q_we;
  logic [NODE_AW-1:0]          q_raddr;
  logic [NODE_W-1:0]           q_wdata, q_rdata;

  logic cmd_take;
  logic res_free;
  logic edge_ok;
  logic match;
  logic enq;

  assign live_n    = (node_count > COUNT_W'(MAX_NODES)) ? COUNT_W'(MAX_NODES) : node_count;
  assign cmd_ready = (state == ST_IDLE);
  assign cmd_take  = cmd_valid && cmd_ready;
  assign res_free  = !res_valid || res_ready;
  assign ep_inc    = ep + 1'b1;
  assign scan_more = ep_inc < edge_total;
  assign ni_inc    = ni + 1'b1;
  assign e_src     = edge_rdata[2*NODE_W-1:NODE_W];
  assign e_dst     = edge_rdata[NODE_W-1:0];

  assign edge_ok = ({1'b0, source_node} < live_n) && ({1'b0, dest_node} < live_n)
                   && (edge_total < EDGE_CW'(MAX_EDGES));
  assign edge_we = cmd_take && (command == CMD_ADD_EDGE) && edge_ok;

  // Edge condition for the current scan pass
  always_comb begin
    if (releasing) begin
      match = (e_src == node) && ({1'b0, e_dst} < live_n);
    end else begin
      match = ({1'b0, e_src} < live_n) && ({1'b0, e_dst} < live_n);
    end
  end

  // Release enqueues a destination when its in-degree drops to zero
  assign enq = releasing && (deg_rdata == DEG_W'(1)) && (tail < NODE_CW'(MAX_NODES));

  // Next state and memory controls
  always_comb begin
    state_next = state;
    edge_raddr = ep[EDGE_AW-1:0];
    deg_we     = 1'b0;
    deg_waddr  = cur_dst[NODE_AW-1:0];
    deg_wdata  = '0;
    deg_raddr  = e_dst[NODE_AW-1:0];
    q_we       = 1'b0;
    q_wdata    = cur_dst;
    q_raddr    = head[NODE_AW-1:0];
    case (state)
      ST_IDLE: begin
        if (cmd_take && (command == CMD_SORT_NODES)) begin
          state_next = ST_CLEAR;
        end
      end
      ST_CLEAR: begin
        deg_we    = 1'b1;
        deg_waddr = ni[NODE_AW-1:0];
        if (ni == NODE_CW'(MAX_NODES - 1)) begin
          state_next = (edge_total == '0) ? ST_INIT_ISSUE : ST_SCAN_ISSUE;
        end
      end
      ST_SCAN_ISSUE: begin
        state_next = ST_SCAN_CHECK;
      end
      ST_SCAN_CHECK: begin
        if (match) begin
          state_next = ST_SCAN_UPDATE;
        end else if (scan_more) begin
          edge_raddr = ep_inc[EDGE_AW-1:0];
        end else begin
          state_next = releasing ? ST_POP_ISSUE : ST_INIT_ISSUE;
        end
      end
      ST_SCAN_UPDATE: begin
        if (!releasing) begin
          deg_we    = 1'b1;
          deg_wdata = deg_rdata + 1'b1;
        end else if (deg_rdata != '0) begin
          deg_we    = 1'b1;
          deg_wdata = deg_rdata - 1'b1;
        end
        q_we = enq;
        if (scan_more) begin
          edge_raddr = ep_inc[EDGE_AW-1:0];
          state_next = ST_SCAN_CHECK;
        end else begin
          state_next = releasing ? ST_POP_ISSUE : ST_INIT_ISSUE;
        end
      end
      ST_INIT_ISSUE: begin
        deg_raddr = ni[NODE_AW-1:0];
        state_next = ({1'b0, ni} >= {1'b0, live_n}) ? ST_POP_ISSUE : ST_INIT_CHECK;
      end
      ST_INIT_CHECK: begin
        q_wdata    = NODE_W'(ni);
        q_we       = (deg_rdata == '0) && (tail < NODE_CW'(MAX_NODES));
        state_next = ST_INIT_ISSUE;
      end
      ST_POP_ISSUE: begin
        state_next = (head == tail) ? ST_EMIT_ISSUE : ST_POP_DATA;
      end
      ST_POP_DATA: begin
        state_next = (edge_total == '0) ? ST_POP_ISSUE : ST_SCAN_ISSUE;
      end
      ST_EMIT_ISSUE: begin
        q_raddr = ni[NODE_AW-1:0];
        if (res_free) begin
          state_next = (tail == '0) ? ST_IDLE : ST_EMIT_DATA;
        end
      end
      ST_EMIT_DATA: begin
        state_next = (ni_inc == tail) ? ST_IDLE : ST_EMIT_ISSUE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Hold the sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Configuration register and edge count
  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= '0;
      edge_total <= '0;
    end else begin
      if (cfg_wr_en) begin
        node_count <= cfg_wr_data;
      end
      if (edge_we) begin
        edge_total <= edge_total + 1'b1;
      end else if (cmd_take && (command == CMD_CLEAR_EDGES)) begin
        edge_total <= '0;
      end
    end
  end

  // Advance counters and queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      tail      <= '0;
      ni        <= '0;
      ep        <= '0;
      releasing <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          ni        <= '0;
          ep        <= '0;
          releasing <= 1'b0;
        end
        ST_CLEAR: begin
          if (ni == NODE_CW'(MAX_NODES - 1)) begin
            ni   <= '0;
            head <= '0;
            tail <= '0;
          end else begin
            ni <= ni_inc;
          end
        end
        ST_SCAN_CHECK: begin
          if (match) begin
            cur_dst <= e_dst;
          end else if (scan_more) begin
            ep <= ep_inc;
          end
        end
        ST_SCAN_UPDATE: begin
          if (enq) begin
            tail <= tail + 1'b1;
          end
          if (scan_more) begin
            ep <= ep_inc;
          end
        end
        ST_INIT_ISSUE: begin
          if ({1'b0, ni} >= {1'b0, live_n}) begin
            ni <= '0;
          end
        end
        ST_INIT_CHECK: begin
          if ((deg_rdata == '0) && (tail < NODE_CW'(MAX_NODES))) begin
            tail <= tail + 1'b1;
          end
          ni <= ni_inc;
        end
        ST_POP_ISSUE: begin
          if (head == tail) begin
            cyc <= {1'b0, tail} < {1'b0, live_n};
          end
        end
        ST_POP_DATA: begin
          node      <= q_rdata;
          head      <= head + 1'b1;
          releasing <= 1'b1;
          ep        <= '0;
        end
        ST_EMIT_DATA: begin
          ni <= ni_inc;
        end
        default: begin
        end
      endcase
    end
  end

  // Output register: load a result, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if ((state == ST_EMIT_ISSUE) && res_free && (tail == '0)) begin
      res_valid <= 1'b1;
    end else if (state == ST_EMIT_DATA) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_EMIT_ISSUE) && res_free && (tail == '0)) begin
      node_index  <= '0;
      has_node    <= 1'b0;
      last_of_run <= 1'b1;
      cycle_found <= cyc;
    end else if (state == ST_EMIT_DATA) begin
      node_index  <= q_rdata;
      has_node    <= 1'b1;
      last_of_run <= (ni_inc == tail);
      cycle_found <= cyc;
    end
  end

  // Edge store: source and destination side by side
  tse_ram #(
    .WIDTH (2*NODE_W),
    .DEPTH (MAX_EDGES)
  ) u_edge_ram (
    .clk   (clk),
    .we    (edge_we),
    .waddr (edge_total[EDGE_AW-1:0]),
    .wdata ({source_node, dest_node}),
    .raddr (edge_raddr),
    .rdata (edge_rdata)
  );

  // In-degree per node
  tse_ram #(
    .WIDTH (DEG_W),
    .DEPTH (MAX_NODES)
  ) u_deg_ram (
    .clk   (clk),
    .we    (deg_we),
    .waddr (deg_waddr),
    .wdata (deg_wdata),
    .raddr (deg_raddr),
    .rdata (deg_rdata)
  );

  // Ready queue, which also holds the emitted order
  tse_ram #(
    .WIDTH (NODE_W),
    .DEPTH (MAX_NODES)
  ) u_queue_ram (
    .clk   (clk),
    .we    (q_we),
    .waddr (tail[NODE_AW-1:0]),
    .wdata (q_wdata),
    .raddr (q_raddr),
    .rdata (q_rdata)
  );

endmodule

// ----- verif/topological_sort_engine_unit_test.sv -----
module topological_sort_engine_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import tse_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int unsigned RANDOM_ITEMS = 100;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned DRAIN_CYCLES = 200;
  localparam int unsigned WATCHDOG_LIMIT = 200000;

  typedef enum logic {ITEM_CMD, ITEM_CFG} item_kind_t;

  typedef struct {
    item_kind_t         kind;
    logic [CMD_W-1:0]   cmd;
    logic [NODE_W-1:0]  src;
    logic [NODE_W-1:0]  dst;
    logic [COUNT_W-1:0] nodes;
  } graph_op_t;

  typedef struct packed {
    logic [NODE_W-1:0] node_index;
    logic              has_node;
    logic              last_of_run;
    logic              cycle_found;
  } order_entry_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_wr_en = 1'b0;
  logic [COUNT_W-1:0] cfg_wr_data = '0;
  logic               cmd_valid = 1'b0;
  logic               cmd_ready;
  logic [CMD_W-1:0]   command = '0;
  logic [NODE_W-1:0]  source_node = '0;
  logic [NODE_W-1:0]  dest_node = '0;
  logic               res_valid;
  logic               res_ready = 1'b0;
  logic [NODE_W-1:0]  node_index;
  logic               has_node;
  logic               last_of_run;
  logic               cycle_found;

  // Operations still to send, and sort results still owed by the block
  graph_op_t    graph_ops[$];
  order_entry_t order_due[$];

  // Mirror of the block's graph state
  logic [NODE_W-1:0]  edge_src_mem [MAX_EDGES];
  logic [NODE_W-1:0]  edge_dst_mem [MAX_EDGES];
  int unsigned        edge_fill = 0;
  logic [COUNT_W-1:0] node_setting = '0;

  int unsigned mismatches = 0;
  int unsigned send_gap = 0;
  int unsigned send_calm = 0;
  int unsigned recv_gap = 0;
  int unsigned recv_calm = 0;
  int unsigned settle = 0;
  int unsigned quiet_cycles = 0;
  logic        write_now;

  topological_sort_engine_unit i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd_valid   (cmd_valid),
    .cmd_ready   (cmd_ready),
    .command     (command),
    .source_node (source_node),
    .dest_node   (dest_node),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .node_index  (node_index),
    .has_node    (has_node),
    .last_of_run (last_of_run),
    .cycle_found (cycle_found)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Mostly short gaps, a few long ones, and now and then a calm stretch
  function automatic int unsigned pick_gap(inout int unsigned calm);
    int unsigned r;
    if (calm != 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 5) begin
      calm = $urandom_range(20, 60);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void queue_cmd(logic [CMD_W-1:0] cmd, int unsigned src,
                                    int unsigned dst);
    graph_op_t op;
    op.kind = ITEM_CMD;
    op.cmd = cmd;
    op.src = NODE_W'(src);
    op.dst = NODE_W'(dst);
    op.nodes = '0;
    graph_ops.push_back(op);
  endfunction

  function automatic void queue_nodes(logic [COUNT_W-1:0] nodes);
    graph_op_t op;
    op.kind = ITEM_CFG;
    op.cmd = CMD_UNUSED;
    op.src = '0;
    op.dst = '0;
    op.nodes = nodes;
    graph_ops.push_back(op);
  endfunction

  // Kahn ordering over the mirrored edge store; stale edges are skipped
  function automatic void predict_order(int unsigned lim);
    int unsigned       indeg [MAX_NODES];
    logic [NODE_W-1:0] order [MAX_NODES];
    logic [NODE_W-1:0] node;
    int unsigned       head;
    int unsigned       tail;
    int unsigned       e;
    int unsigned       i;
    logic              short_run;
    order_entry_t      ent;
    for (i = 0; i < MAX_NODES; i++) indeg[i] = 0;
    for (e = 0; e < edge_fill; e++) begin
      if (edge_src_mem[e] < lim && edge_dst_mem[e] < lim) indeg[edge_dst_mem[e]]++;
    end
    // seed with the sources in index order
    tail = 0;
    for (i = 0; i < lim; i++) begin
      if (indeg[i] == 0) begin
        order[tail] = NODE_W'(i);
        tail++;
      end
    end
    // release destinations as their last incoming edge is consumed
    head = 0;
    while (head < tail) begin
      node = order[head];
      head++;
      for (e = 0; e < edge_fill; e++) begin
        if (edge_src_mem[e] == node && edge_dst_mem[e] < lim &&
            indeg[edge_dst_mem[e]] != 0) begin
          indeg[edge_dst_mem[e]]--;
          if (indeg[edge_dst_mem[e]] == 0) begin
            order[tail] = edge_dst_mem[e];
            tail++;
          end
        end
      end
    end
    short_run = (tail < lim);
    if (tail == 0) begin
      ent.node_index = '0;
      ent.has_node = 1'b0;
      ent.last_of_run = 1'b1;
      ent.cycle_found = short_run;
      order_due.push_back(ent);
    end else begin
      for (i = 0; i < tail; i++) begin
        ent.node_index = order[i];
        ent.has_node = 1'b1;
        ent.last_of_run = (i == tail - 1);
        ent.cycle_found = short_run;
        order_due.push_back(ent);
      end
    end
  endfunction

  function automatic void track_command(logic [CMD_W-1:0] cmd, logic [NODE_W-1:0] src,
                                        logic [NODE_W-1:0] dst);
    int unsigned lim;
    lim = (node_setting > MAX_NODES) ? MAX_NODES : node_setting;
    case (cmd)
      CMD_ADD_EDGE: begin
        if (src < lim && dst < lim && edge_fill < MAX_EDGES) begin
          edge_src_mem[edge_fill] = src;
          edge_dst_mem[edge_fill] = dst;
          edge_fill++;
        end
      end
      CMD_CLEAR_EDGES: begin
        edge_fill = 0;
      end
      CMD_SORT_NODES: begin
        predict_order(lim);
      end
      default: begin
      end
    endcase
  endfunction

  function automatic void compare_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // Send operations; register writes wait until the block is idle and drained
  always @(posedge clk) begin : drive_ops
    if (rst) begin
      cmd_valid <= 1'b0;
      cfg_wr_en <= 1'b0;
      send_gap = 0;
      settle = 0;
    end else begin
      write_now = 1'b0;
      if (cmd_valid && cmd_ready) track_command(command, source_node, dest_node);
      if (cmd_valid && !cmd_ready) begin
        // hold the transaction until it is taken
      end else if (graph_ops.size() == 0) begin
        cmd_valid <= 1'b0;
      end else if (graph_ops[0].kind == ITEM_CFG) begin
        cmd_valid <= 1'b0;
        if (!cmd_valid && cmd_ready && order_due.size() == 0) settle++;
        else settle = 0;
        if (settle > SETTLE_CYCLES) begin
          write_now = 1'b1;
          cfg_wr_data <= graph_ops[0].nodes;
          node_setting = graph_ops[0].nodes;
          void'(graph_ops.pop_front());
          settle = 0;
        end
      end else if (send_gap != 0) begin
        send_gap--;
        cmd_valid <= 1'b0;
      end else begin
        cmd_valid <= 1'b1;
        command <= graph_ops[0].cmd;
        source_node <= graph_ops[0].src;
        dest_node <= graph_ops[0].dst;
        void'(graph_ops.pop_front());
        send_gap = pick_gap(send_calm);
      end
      cfg_wr_en <= write_now;
    end
  end

  // Check each result transaction against the oldest expectation
  always @(posedge clk) begin : watch_results
    order_entry_t want;
    if (rst) begin
      res_ready <= 1'b0;
      recv_gap = 0;
    end else begin
      if (res_valid && res_ready) begin
        if (order_due.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual node %0d has %0b last %0b cycle %0b",
                   $time, node_index, has_node, last_of_run, cycle_found);
          mismatches++;
        end else begin
          want = order_due.pop_front();
          compare_field("node_index", want.node_index, node_index);
          compare_field("has_node", want.has_node, has_node);
          compare_field("last_of_run", want.last_of_run, last_of_run);
          compare_field("cycle_found", want.cycle_found, cycle_found);
        end
      end
      if (recv_gap != 0) begin
        recv_gap--;
        res_ready <= 1'b0;
      end else begin
        res_ready <= 1'b1;
        if (res_valid && res_ready) recv_gap = pick_gap(recv_calm);
      end
    end
  end

  // Abort when no transaction moves for too long
  always @(posedge clk) begin
    if (rst || (cmd_valid && cmd_ready) || (res_valid && res_ready) || cfg_wr_en) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int unsigned n;
    int unsigned lim;
    int unsigned a;
    int unsigned b;
    int unsigned r;
    int unsigned counted;

    // no nodes in use: empty order without a cycle, edges dropped
    queue_cmd(CMD_SORT_NODES, 0, 0);
    queue_cmd(CMD_ADD_EDGE, 0, 0);
    queue_cmd(CMD_UNUSED, 6'h3f, 6'h3f);
    // oversized node count clamps to the maximum: every node in index order
    queue_nodes(7'h7f);
    queue_cmd(CMD_SORT_NODES, 6'h3f, 6'h3f);
    // two-node cycle at the extremes, a self loop and a duplicated edge
    queue_cmd(CMD_ADD_EDGE, 6'h3f, 0);
    queue_cmd(CMD_ADD_EDGE, 0, 6'h3f);
    queue_cmd(CMD_ADD_EDGE, 5, 5);
    queue_cmd(CMD_ADD_EDGE, 1, 2);
    queue_cmd(CMD_ADD_EDGE, 1, 2);
    queue_cmd(CMD_ADD_EDGE, 2, 3);
    queue_cmd(CMD_SORT_NODES, 0, 0);
    // shrink the graph: stale edges are ignored, out-of-range edges dropped
    queue_nodes(4);
    queue_cmd(CMD_ADD_EDGE, 4, 0);
    queue_cmd(CMD_ADD_EDGE, 0, 4);
    queue_cmd(CMD_SORT_NODES, 0, 0);
    // every node on a cycle: empty order with the cycle flag
    queue_nodes(2);
    queue_cmd(CMD_ADD_EDGE, 0, 1);
    queue_cmd(CMD_ADD_EDGE, 1, 0);
    queue_cmd(CMD_SORT_NODES, 0, 0);
    queue_cmd(CMD_CLEAR_EDGES, 6'h3f, 6'h3f);
    queue_cmd(CMD_SORT_NODES, 0, 0);

    // fill the edge store, then offer back edges that must be dropped
    queue_nodes(64);
    queue_cmd(CMD_CLEAR_EDGES, 0, 0);
    repeat (MAX_EDGES) begin
      a = $urandom_range(0, 62);
      b = $urandom_range(a + 1, 63);
      queue_cmd(CMD_ADD_EDGE, a, b);
    end
    repeat (4) begin
      a = $urandom_range(1, 63);
      b = $urandom_range(0, a);
      queue_cmd(CMD_ADD_EDGE, a, b);
    end
    queue_cmd(CMD_SORT_NODES, 0, 0);
    queue_cmd(CMD_CLEAR_EDGES, 0, 0);

    // random graphs: mostly acyclic edge lists, some cycles and noise
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      r = $urandom_range(0, 9);
      if (r == 0) n = $urandom_range(65, 127);
      else if (r == 1) n = $urandom_range(17, 64);
      else n = $urandom_range(0, 16);
      queue_nodes(COUNT_W'(n));
      lim = (n > MAX_NODES) ? MAX_NODES : n;
      repeat ($urandom_range(1, 3)) begin
        if ($urandom_range(0, 3) != 0) begin
          queue_cmd(CMD_CLEAR_EDGES, $urandom, $urandom);
          counted++;
        end
        repeat ($urandom_range(0, 12)) begin
          r = $urandom_range(0, 99);
          if (lim >= 2 && r < 75) begin
            a = $urandom_range(0, lim - 2);
            b = $urandom_range(a + 1, lim - 1);
            queue_cmd(CMD_ADD_EDGE, a, b);
            counted++;
          end else if (lim >= 1 && r < 88) begin
            queue_cmd(CMD_ADD_EDGE, $urandom_range(0, lim - 1), $urandom_range(0, lim - 1));
            counted++;
          end else if (r < 95) begin
            queue_cmd(CMD_ADD_EDGE, $urandom, $urandom);
          end else begin
            queue_cmd(CMD_UNUSED, $urandom, $urandom);
          end
        end
        queue_cmd(CMD_SORT_NODES, $urandom, $urandom);
        counted++;
      end
    end
    queue_nodes(0);
    queue_cmd(CMD_SORT_NODES, 0, 0);

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // drain: every operation sent, every result back, then a quiet spell
    while (graph_ops.size() != 0 || cmd_valid) @(posedge clk);
    while (order_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && order_due.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
